@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the switch decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the switch decoder modules.
// ----------------------------------------------------------------------------
package psd_pkg;

	// Number of receiver channels and field widths.
	localparam int NUM_CH   = 3;
	localparam int CNT_W    = 8;
	localparam int CODE_W   = 2;
	localparam int REG_W    = 8;
	localparam int REG_IDX_W = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// Register indexes on the write port.
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;

	// Register reset values.
	localparam logic [REG_W-1:0] WINDOW_LENGTH_RST  = 8'd250;
	localparam logic [REG_W-1:0] LOW_THRESHOLD_RST  = 8'd100;
	localparam logic [REG_W-1:0] HIGH_THRESHOLD_RST = 8'd200;

	// Request kinds on the input channel.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// Bit positions of the seen-class marks.
	localparam int SEEN_UP_BIT     = 0;
	localparam int SEEN_MIDDLE_BIT = 1;
	localparam int SEEN_DOWN_BIT   = 2;

	// Switch position of one channel.
	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_UP     = 2'd1,
		CLS_MIDDLE = 2'd2,
		CLS_DOWN   = 2'd3
	} class_t;

	// Channel 0 command codes.
	localparam logic [CODE_W-1:0] CMD_UP     = 2'd0;
	localparam logic [CODE_W-1:0] CMD_MIDDLE = 2'd1;
	localparam logic [CODE_W-1:0] CMD_DOWN   = 2'd2;

	// Control handed from the top level to every lane.
	typedef struct packed {
		logic             tick;
		logic             poll;
		logic             window_end;
		logic [REG_W-1:0] low_threshold;
		logic [REG_W-1:0] high_threshold;
	} lane_ctl_t;

	// Class pair a lane reports for the poll in progress.
	typedef struct packed {
		class_t cur;
		class_t prev;
	} lane_stat_t;

endpackage

@@ rtl/psd_lane.sv @@
// ----------------------------------------------------------------------------
// psd_lane
// One channel: counts high samples, classifies at window end, keeps the
// seen marks and the current and previous switch position.
// ----------------------------------------------------------------------------
module psd_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psd_pkg::lane_ctl_t    ctl,
	input  logic                  pin,
	output psd_pkg::lane_stat_t   stat
);
	import psd_pkg::*;

	logic [CNT_W-1:0] high_q;
	logic [2:0]       seen_q;
	class_t           cur_q;
	class_t           prev_q;

	logic [CNT_W-1:0] high_next;
	logic [2:0]       seen_new;
	class_t           cur_new;

	// Saturating high-sample count including this tick's sample.
	assign high_next = (pin && (high_q != {CNT_W{1'b1}})) ? high_q + 1'b1 : high_q;

	// Classify the closing count into a seen mark.
	always_comb begin
		seen_new = '0;
		if ((high_next >= ctl.low_threshold) && (high_next <= ctl.high_threshold)) begin
			seen_new[SEEN_MIDDLE_BIT] = 1'b1;
		end else if (high_next < ctl.low_threshold) begin
			seen_new[SEEN_DOWN_BIT] = 1'b1;
		end else begin
			seen_new[SEEN_UP_BIT] = 1'b1;
		end
	end

	// Pick the position from the classes seen since the last poll.
	always_comb begin
		priority if (seen_q[SEEN_MIDDLE_BIT]) begin
			cur_new = CLS_MIDDLE;
		end else if (seen_q[SEEN_UP_BIT]) begin
			cur_new = CLS_UP;
		end else if (seen_q[SEEN_DOWN_BIT]) begin
			cur_new = CLS_DOWN;
		end else begin
			cur_new = cur_q;
		end
	end

	assign stat.cur  = cur_new;
	assign stat.prev = prev_q;

	// Lane state updates for ticks and polls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= '0;
			seen_q <= '0;
			cur_q  <= CLS_NONE;
			prev_q <= CLS_NONE;
		end else if (ctl.tick) begin
			if (ctl.window_end) begin
				high_q <= '0;
				seen_q <= seen_q | seen_new;
			end else begin
				high_q <= high_next;
			end
		end else if (ctl.poll) begin
			seen_q <= '0;
			cur_q  <= cur_new;
			prev_q <= cur_new;
		end
	end

endmodule

@@ rtl/psd_merge.sv @@
// ----------------------------------------------------------------------------
// psd_merge
// Combines the lane positions into the poll result: up events on channels
// 1 and 2, the channel 0 command with its arming, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       poll,
	input  psd_pkg::lane_stat_t [psd_pkg::NUM_CH-1:0]  stat,
	input  logic                                       m_tready,
	output logic                                       m_tvalid,
	// m_tdata: chan1_up_event, chan2_up_event, chan0_event_valid,
	// chan0_event_code[1:0], zero fill.
	output logic [psd_pkg::OUT_DATA_W-1:0]             m_tdata
);
	import psd_pkg::*;

	logic              armed_q;
	logic              valid_q;
	logic              ev1_q;
	logic              ev2_q;
	logic              cmd_valid_q;
	logic [CODE_W-1:0] cmd_code_q;

	logic              ev1;
	logic              ev2;
	logic              cmd_valid;
	logic [CODE_W-1:0] cmd_code;
	logic              arm_set;

	// Up entries on channels 1 and 2.
	assign ev1 = (stat[1].cur == CLS_UP) && (stat[1].prev != CLS_UP);
	assign ev2 = (stat[2].cur == CLS_UP) && (stat[2].prev != CLS_UP);

	// Channel 0 command; the first middle entry only arms.
	always_comb begin
		cmd_valid = 1'b0;
		cmd_code  = CMD_UP;
		arm_set   = 1'b0;
		priority if ((stat[0].cur == CLS_UP) && (stat[0].prev != CLS_UP)) begin
			cmd_valid = armed_q;
		end else if ((stat[0].cur == CLS_MIDDLE) && (stat[0].prev != CLS_MIDDLE)) begin
			cmd_valid = armed_q;
			cmd_code  = armed_q ? CMD_MIDDLE : CMD_UP;
			arm_set   = !armed_q;
		end else if ((stat[0].cur == CLS_DOWN) && (stat[0].prev != CLS_DOWN)) begin
			cmd_valid = armed_q;
			cmd_code  = armed_q ? CMD_DOWN : CMD_UP;
		end else begin
			cmd_valid = 1'b0;
		end
	end

	// Arming flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (poll && arm_set) begin
				armed_q <= 1'b1;
			end
			if (poll) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded on each poll.
	always_ff @(posedge clk) begin
		if (poll) begin
			ev1_q       <= ev1;
			ev2_q       <= ev2;
			cmd_valid_q <= cmd_valid;
			cmd_code_q  <= cmd_code;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_DATA_W-CODE_W-3){1'b0}}, cmd_code_q, cmd_valid_q, ev2_q, ev1_q};

	// A command is only issued once channel 0 is armed.
	`ASSERT_IMP(a_cmd_needs_arm, clk, arst_n, poll && cmd_valid, armed_q)
	// Arming is never withdrawn.
	`ASSERT_NEXT(a_arm_sticky, clk, arst_n, armed_q, armed_q)
	// A delivered command carries a defined code.
	`ASSERT_IMP(a_code_defined, clk, arst_n, valid_q && cmd_valid_q, cmd_code_q != 2'd3)

endmodule

@@ rtl/pwm_three_position_switch_decoder.sv @@
// ----------------------------------------------------------------------------
// pwm_three_position_switch_decoder
// Three-channel receiver switch decoder with window counting per lane.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  s_tuser kind, s_tdata pin_levels
//   m_*      out  m_tvalid/m_tready  m_tdata events and channel 0 command
//   wr_*     in   wr_en              wr_index, wr_data
//
// Ticks update the lane counters at the accepting edge, and polls load the
// output register at the accepting edge, so the report is offered from the
// next cycle on.
// A new request is taken whenever the output register is empty or drained
// in the same cycle, so with m_tready high one request enters per cycle.
// Ticks give no result. Reset clears counters, marks, positions and arming.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_three_position_switch_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata: pin_levels[2:0], zero fill.
	input  logic [psd_pkg::IN_DATA_W-1:0]        s_tdata,
	// s_tuser: kind.
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata: chan1_up_event, chan2_up_event, chan0_event_valid,
	// chan0_event_code[1:0], zero fill.
	output logic [psd_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                 wr_en,
	input  logic [psd_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [psd_pkg::REG_W-1:0]            wr_data
);
	import psd_pkg::*;

	logic [REG_W-1:0] window_length_q;
	logic [REG_W-1:0] low_threshold_q;
	logic [REG_W-1:0] high_threshold_q;
	logic [CNT_W-1:0] window_count_q;

	logic       accept;
	logic       tick;
	logic       poll;
	logic       window_end;
	lane_ctl_t  ctl;
	lane_stat_t [NUM_CH-1:0] stat;

	// Request acceptance.
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign tick     = accept && (s_tuser == KIND_TICK);
	assign poll     = accept && (s_tuser == KIND_POLL);

	// Window closes on the tick that brings the count to the configured length or past it.
	assign window_end = ({1'b0, window_count_q} + 9'd1) >= {1'b0, window_length_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q  <= WINDOW_LENGTH_RST;
			low_threshold_q  <= LOW_THRESHOLD_RST;
			high_threshold_q <= HIGH_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WINDOW_LENGTH:  window_length_q  <= wr_data;
				REG_LOW_THRESHOLD:  low_threshold_q  <= wr_data;
				REG_HIGH_THRESHOLD: high_threshold_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Shared window tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= '0;
		end else if (tick) begin
			window_count_q <= window_end ? '0 : window_count_q + 1'b1;
		end
	end

	assign ctl.tick           = tick;
	assign ctl.poll           = poll;
	assign ctl.window_end     = window_end;
	assign ctl.low_threshold  = low_threshold_q;
	assign ctl.high_threshold = high_threshold_q;

	// One lane per receiver channel.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		psd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.pin    (s_tdata[c]),
			.stat   (stat[c])
		);
	end

	// Result merge and output register.
	psd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.poll     (poll),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// A closing tick restarts the window count.
	`ASSERT_NEXT(a_window_restart, clk, arst_n, tick && window_end, window_count_q == '0)
	// Every accepted poll leaves a result waiting.
	`ASSERT_NEXT(a_poll_result, clk, arst_n, poll, m_tvalid)
	// An empty output register always lets a request in.
	`ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

endmodule

@@ bench/tb_pwm_three_position_switch_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pwm_three_position_switch_decoder
// Self-checking bench for the three-channel switch decoder. A queue-fed
// driver offers tick and poll requests. A monitor runs a local model of the
// window counting, the class choice and the channel 0 arming on every
// accepted request. It compares each poll report field by field against the
// oldest prediction. Several register settings are covered, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_pwm_three_position_switch_decoder;
	import psd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic       kind;
		logic [2:0] pins;
	} switch_req_t;

	typedef struct {
		logic              ch1_up;
		logic              ch2_up;
		logic              cmd_valid;
		logic [CODE_W-1:0] cmd_code;
	} poll_report_t;

	// Block ports.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [REG_W-1:0]      wr_data = '0;

	// Request and report bookkeeping.
	switch_req_t  pending_reqs_q[$];
	switch_req_t  next_req;
	poll_report_t pending_reports_q[$];
	int           pushed_reqs = 0;
	int           accepted_reqs = 0;
	int           checked_polls = 0;
	int           settings_used = 0;
	int           errors = 0;
	int           cycles = 0;
	int           send_idle_pct = 34;
	int           recv_idle_pct = 34;
	bit           hold_req = 1'b0;
	int           hold_left = 0;

	// Local copy of the decoder registers and state.
	logic [REG_W-1:0] cfg_window = WINDOW_LENGTH_RST;
	logic [REG_W-1:0] cfg_low = LOW_THRESHOLD_RST;
	logic [REG_W-1:0] cfg_high = HIGH_THRESHOLD_RST;
	logic [CNT_W-1:0] win_count = '0;
	logic [CNT_W-1:0] high_count[NUM_CH] = '{default: '0};
	logic [2:0]       seen_marks[NUM_CH] = '{default: '0};
	class_t           cur_cls[NUM_CH] = '{default: CLS_NONE};
	class_t           prev_cls[NUM_CH] = '{default: CLS_NONE};
	logic             cmd_armed = 1'b0;

	pwm_three_position_switch_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d (poll %0d)", what, got, want,
			checked_polls);
		errors++;
	endtask

	// Advances the local decoder model by one request; a poll queues its report.
	task automatic decode_request(input logic kind, input logic [2:0] pins);
		poll_report_t rep;
		class_t       cur;
		class_t       prv;
		logic [2:0]   s;
		int           c;
		if (kind == KIND_TICK) begin
			for (c = 0; c < NUM_CH; c++) begin
				if (pins[c] && high_count[c] != 8'hFF)
					high_count[c]++;
			end
			// The closing tick's sample belongs to the window it closes.
			if ({1'b0, win_count} + 9'd1 >= {1'b0, cfg_window}) begin
				win_count = '0;
				for (c = 0; c < NUM_CH; c++) begin
					if (high_count[c] >= cfg_low && high_count[c] <= cfg_high)
						seen_marks[c][SEEN_MIDDLE_BIT] = 1'b1;
					else if (high_count[c] < cfg_low)
						seen_marks[c][SEEN_DOWN_BIT] = 1'b1;
					else
						seen_marks[c][SEEN_UP_BIT] = 1'b1;
					high_count[c] = '0;
				end
			end else begin
				win_count++;
			end
		end else begin
			// Middle wins over up, up over down; nothing seen keeps the class.
			for (c = 0; c < NUM_CH; c++) begin
				s = seen_marks[c];
				if (s[SEEN_MIDDLE_BIT])
					cur_cls[c] = CLS_MIDDLE;
				else if (s[SEEN_UP_BIT])
					cur_cls[c] = CLS_UP;
				else if (s[SEEN_DOWN_BIT])
					cur_cls[c] = CLS_DOWN;
				seen_marks[c] = '0;
			end
			rep.ch1_up = (cur_cls[1] == CLS_UP && prev_cls[1] != CLS_UP);
			rep.ch2_up = (cur_cls[2] == CLS_UP && prev_cls[2] != CLS_UP);
			prev_cls[1] = cur_cls[1];
			prev_cls[2] = cur_cls[2];
			rep.cmd_valid = 1'b0;
			rep.cmd_code = CMD_UP;
			cur = cur_cls[0];
			prv = prev_cls[0];
			// Channel 0 commands need arming; the first middle entry arms.
			if (cur == CLS_UP && prv != CLS_UP) begin
				if (cmd_armed) begin
					rep.cmd_valid = 1'b1;
					rep.cmd_code = CMD_UP;
				end
			end else if (cur == CLS_MIDDLE && prv != CLS_MIDDLE) begin
				if (cmd_armed) begin
					rep.cmd_valid = 1'b1;
					rep.cmd_code = CMD_MIDDLE;
				end else begin
					cmd_armed = 1'b1;
				end
			end else if (cur == CLS_DOWN && prv != CLS_DOWN) begin
				if (cmd_armed) begin
					rep.cmd_valid = 1'b1;
					rep.cmd_code = CMD_DOWN;
				end
			end
			prev_cls[0] = cur;
			pending_reports_q.push_back(rep);
		end
	endtask

	// Request driver: holds each request until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_reqs_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = pending_reqs_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.kind;
				s_tdata <= {{(IN_DATA_W-3){1'b0}}, next_req.pins};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Report receiver: random stalls plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: model every accepted request and check every taken report.
	always @(posedge clk) begin : monitor
		poll_report_t want;
		if (arst_n && s_tvalid && s_tready) begin
			decode_request(s_tuser, s_tdata[2:0]);
			accepted_reqs++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports_q.size() == 0) begin
				report_mismatch("report with no poll waiting", m_tdata, 0);
			end else begin
				want = pending_reports_q.pop_front();
				if (m_tdata[0] !== want.ch1_up)
					report_mismatch("chan1_up_event", m_tdata[0], want.ch1_up);
				if (m_tdata[1] !== want.ch2_up)
					report_mismatch("chan2_up_event", m_tdata[1], want.ch2_up);
				if (m_tdata[2] !== want.cmd_valid)
					report_mismatch("chan0_event_valid", m_tdata[2], want.cmd_valid);
				if (m_tdata[4:3] !== want.cmd_code)
					report_mismatch("chan0_event_code", m_tdata[4:3], want.cmd_code);
				if (m_tdata[OUT_DATA_W-1:5] !== '0)
					report_mismatch("m_tdata fill bits", m_tdata[OUT_DATA_W-1:5], 0);
			end
			checked_polls++;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d reports still due", cycles,
				pending_reports_q.size());
			$display("tb_pwm_three_position_switch_decoder: done, errors");
			$finish;
		end
	end

	task automatic push_request(input logic kind, input logic [2:0] pins);
		switch_req_t r;
		r.kind = kind;
		r.pins = pins;
		pending_reqs_q.push_back(r);
		pushed_reqs++;
	endtask

	// Writes all three registers on consecutive edges; the block is idle here.
	task automatic configure(input logic [REG_W-1:0] win, input logic [REG_W-1:0] lo,
			input logic [REG_W-1:0] hi);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_WINDOW_LENGTH;
		wr_data <= win;
		cfg_window = win;
		@(posedge clk);
		wr_index <= REG_LOW_THRESHOLD;
		wr_data <= lo;
		cfg_low = lo;
		@(posedge clk);
		wr_index <= REG_HIGH_THRESHOLD;
		wr_data <= hi;
		cfg_high = hi;
		@(posedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// Waits until every request is taken and every report checked, then lets
	// trailing ticks finish inside the block.
	task automatic wait_idle();
		@(negedge clk);
		while (accepted_reqs != pushed_reqs || pending_reports_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly whole windows with a set high-sample density per channel, most
	// runs closed by a poll, and some loose requests as noise.
	task automatic gen_traffic(input int budget);
		int         n;
		int         c;
		int         t;
		int         w;
		int         prob[NUM_CH];
		logic [2:0] pins;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 99) < 85) begin
				w = (cfg_window == 0) ? 1 : int'(cfg_window);
				repeat ($urandom_range(1, 2)) begin
					for (c = 0; c < NUM_CH; c++)
						prob[c] = 25 * $urandom_range(0, 4);
					for (t = 0; t < w; t++) begin
						for (c = 0; c < NUM_CH; c++)
							pins[c] = ($urandom_range(0, 99) < prob[c]);
						push_request(KIND_TICK, pins);
						n++;
					end
				end
				if ($urandom_range(0, 99) < 80) begin
					push_request(KIND_POLL, 3'($urandom));
					n++;
				end
			end else begin
				push_request(1'($urandom), 3'($urandom));
				n++;
			end
		end
	endtask

	initial begin
		int i;
		int w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: window of three, counts 0 down, 1..2 middle, 3 up.
		configure(8'd3, 8'd1, 8'd2);
		// Poll with nothing seen keeps every class at none.
		push_request(KIND_POLL, 3'b000);
		// All up: channel 1 and 2 events, channel 0 not armed yet.
		for (i = 0; i < 3; i++) push_request(KIND_TICK, 3'b111);
		push_request(KIND_POLL, 3'b111);
		// Channel 0 middle arms without a command.
		push_request(KIND_TICK, 3'b001);
		push_request(KIND_TICK, 3'b001);
		push_request(KIND_TICK, 3'b000);
		push_request(KIND_POLL, 3'b000);
		// Channel 0 up gives the up command; the others go middle.
		push_request(KIND_TICK, 3'b111);
		push_request(KIND_TICK, 3'b101);
		push_request(KIND_TICK, 3'b011);
		push_request(KIND_POLL, 3'b000);
		// Up then middle in one poll interval: middle wins.
		for (i = 0; i < 3; i++) push_request(KIND_TICK, 3'b111);
		push_request(KIND_TICK, 3'b111);
		push_request(KIND_TICK, 3'b111);
		push_request(KIND_TICK, 3'b000);
		push_request(KIND_POLL, 3'b000);
		// All down: down command; a second poll sees nothing new.
		for (i = 0; i < 3; i++) push_request(KIND_TICK, 3'b000);
		push_request(KIND_POLL, 3'b000);
		push_request(KIND_POLL, 3'b101);
		wait_idle();

		// Zero window length acts as one tick; low above high leaves no middle.
		configure(8'd0, 8'd1, 8'd0);
		gen_traffic(220);
		wait_idle();

		// Widest window, everything middle; trailing ticks leave a long count.
		configure(8'd255, 8'd0, 8'd255);
		gen_traffic(250);
		for (i = 0; i < 30; i++) push_request(KIND_TICK, 3'($urandom));
		wait_idle();

		// Window shortened below the running count, and no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(8'd4, 8'd1, 8'd3);
		gen_traffic(160);
		wait_idle();

		// Long output hold-off while requests keep coming, poll heavy.
		recv_idle_pct = 34;
		configure(8'd5, 8'd2, 8'd3);
		hold_req = 1'b1;
		for (i = 0; i < 120; i++)
			push_request(1'($urandom), 3'($urandom));
		gen_traffic(80);
		wait_idle();
		send_idle_pct = 34;

		// Random small settings.
		repeat (2) begin
			w = $urandom_range(1, 8);
			configure(8'(w), 8'($urandom_range(0, w + 1)), 8'($urandom_range(0, w + 1)));
			gen_traffic(120);
			wait_idle();
		end

		$display("Ran %0d requests under %0d register settings; %0d poll reports checked.",
			accepted_reqs, settings_used, checked_polls);
		if (errors == 0) begin
			$display("tb_pwm_three_position_switch_decoder: done, clean");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("tb_pwm_three_position_switch_decoder: done, errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_lane.sv
rtl/psd_merge.sv
rtl/pwm_three_position_switch_decoder.sv
bench/tb_pwm_three_position_switch_decoder.sv
